// File: hdl/tas_pkg.sv
package tas_pkg;

	// defaults for the top level parameters
	localparam int MAX_TILE_DIM_DEF = 4;
	localparam int TILE_REGS_DEF    = 3;
	localparam int ADDR_BITS_DEF    = 48;

	// fixed field widths of the item and result ports
	localparam int FIELD_ADDR_W = 48;
	localparam int FUNC_W       = 3;
	localparam int DIM_W        = 3;
	localparam int PITCH_W      = 16;
	localparam int BYTES_W      = 8;
	localparam int IDX_W        = 2;
	localparam int KIND_W       = 2;
	localparam int RSTEP_W      = PITCH_W + BYTES_W;
	localparam int NSLOT        = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD      = 3'd0,
		FN_STORE     = 3'd1,
		FN_MAC       = 3'd2,
		FN_GEN_START = 3'd3,
		FN_GEN_STOP  = 3'd4
	} func_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ   = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_MAC    = 2'd2,
		KIND_RESEED = 2'd3
	} kind_t;

	// operand slots of the walk: A (or the load/store tile), B, C
	typedef enum logic [1:0] {
		SLOT_A = 2'd0,
		SLOT_B = 2'd1,
		SLOT_C = 2'd2
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH_A,
		ST_FETCH_B,
		ST_FETCH_C,
		ST_INIT,
		ST_WALK
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic  accept;
		logic  desc_wr;
		logic  gen_set;
		logic  gen_clr;
		logic  reseed;
		logic  fetch;
		slot_t slot;
		logic  init;
		logic  step;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic load_hit;
		logic is_mac;
		logic empty;
		logic last_step;
	} stat_t;

endpackage

// File: hdl/tas_ctrl.sv
module tas_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tas_pkg::FUNC_W-1:0]   func,
	input  tas_pkg::stat_t               stat,
	output logic                         busy,
	output tas_pkg::cmd_t                cmd
);
	import tas_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					unique case (func_t'(func))
						FN_LOAD: begin
							cmd.desc_wr = 1'b1;
							if (stat.load_hit) begin
								cmd.reseed = 1'b1;
							end else begin
								state_d = ST_FETCH_A;
							end
						end
						FN_STORE: begin
							cmd.desc_wr = 1'b1;
							state_d     = ST_FETCH_A;
						end
						FN_MAC:       state_d     = ST_FETCH_A;
						FN_GEN_START: cmd.gen_set = 1'b1;
						FN_GEN_STOP:  cmd.gen_clr = 1'b1;
						default: ;
					endcase
				end
			end
			ST_FETCH_A: begin
				cmd.fetch = 1'b1;
				cmd.slot  = SLOT_A;
				state_d   = stat.is_mac ? ST_FETCH_B : ST_INIT;
			end
			ST_FETCH_B: begin
				cmd.fetch = 1'b1;
				cmd.slot  = SLOT_B;
				state_d   = ST_FETCH_C;
			end
			ST_FETCH_C: begin
				cmd.fetch = 1'b1;
				cmd.slot  = SLOT_C;
				state_d   = ST_INIT;
			end
			ST_INIT: begin
				if (stat.empty) begin
					state_d = ST_IDLE;
				end else begin
					cmd.init = 1'b1;
					state_d  = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (stat.last_step) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: hdl/tas_dp.sv
module tas_dp #(
	parameter int MAX_TILE_DIM = tas_pkg::MAX_TILE_DIM_DEF,
	parameter int TILE_REGS    = tas_pkg::TILE_REGS_DEF,
	parameter int ADDR_BITS    = tas_pkg::ADDR_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tas_pkg::cmd_t                    cmd,
	output tas_pkg::stat_t                   stat,
	input  logic [tas_pkg::FUNC_W-1:0]       func,
	input  logic [tas_pkg::FIELD_ADDR_W-1:0] tile_base,
	input  logic [tas_pkg::DIM_W-1:0]        tile_cols,
	input  logic [tas_pkg::DIM_W-1:0]        tile_rows,
	input  logic [tas_pkg::PITCH_W-1:0]      row_pitch,
	input  logic [tas_pkg::BYTES_W-1:0]      elem_bytes,
	input  logic [tas_pkg::IDX_W-1:0]        dest_tile,
	input  logic [tas_pkg::IDX_W-1:0]        src_a_tile,
	input  logic [tas_pkg::IDX_W-1:0]        src_b_tile,
	output logic                             strobe,
	output logic [tas_pkg::KIND_W-1:0]       kind,
	output logic [tas_pkg::FIELD_ADDR_W-1:0] main_addr,
	output logic [tas_pkg::FIELD_ADDR_W-1:0] b_addr,
	output logic                             b_from_generator,
	output logic                             c_valid,
	output logic [tas_pkg::FIELD_ADDR_W-1:0] c_addr,
	output logic                             last
);
	import tas_pkg::*;

	localparam int TIDX_W = (TILE_REGS > 1) ? $clog2(TILE_REGS) : 1;
	localparam int XIDX_W = TIDX_W + IDX_W;

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		return (v > DIM_W'(MAX_TILE_DIM)) ? DIM_W'(MAX_TILE_DIM) : v;
	endfunction

	function automatic logic [ADDR_BITS-1:0] bytes_ext(input logic [BYTES_W-1:0] b);
		return {{(ADDR_BITS-BYTES_W){1'b0}}, b};
	endfunction

	function automatic logic [FIELD_ADDR_W-1:0] to_field(input logic [ADDR_BITS-1:0] a);
		logic [ADDR_BITS+FIELD_ADDR_W-1:0] wide;
		wide = {{FIELD_ADDR_W{1'b0}}, a};
		return wide[FIELD_ADDR_W-1:0];
	endfunction

	// incoming base wrapped to the address width
	logic [ADDR_BITS+FIELD_ADDR_W-1:0] base_wide;
	logic [ADDR_BITS-1:0]              in_base;
	logic [ADDR_BITS-1:0]              gen_addr_q;
	logic                              in_hit;

	assign base_wide = {{ADDR_BITS{1'b0}}, tile_base};
	assign in_base   = base_wide[ADDR_BITS-1:0];
	assign in_hit    = (in_base != '0) && (in_base == gen_addr_q);

	// generator address, zero means off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_addr_q <= '0;
		end else if (cmd.gen_set) begin
			gen_addr_q <= in_base;
		end else if (cmd.gen_clr) begin
			gen_addr_q <= '0;
		end
	end

	// descriptor write index
	logic [XIDX_W-1:0] dst_wide;
	logic              dst_ok;
	logic [TIDX_W-1:0] dst_i;

	assign dst_wide = {{TIDX_W{1'b0}}, dest_tile};
	assign dst_ok   = dst_wide < XIDX_W'(TILE_REGS);
	assign dst_i    = dst_wide[TIDX_W-1:0];

	// tile descriptors
	logic [ADDR_BITS-1:0]       desc_base_q  [TILE_REGS];
	logic [2*DIM_W-1:0]         desc_shape_q [TILE_REGS];
	logic [RSTEP_W-1:0]         desc_pitch_q [TILE_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TILE_REGS; k++) begin
				desc_base_q[k]  <= '0;
				desc_shape_q[k] <= '0;
				desc_pitch_q[k] <= '0;
			end
		end else if (cmd.desc_wr && dst_ok) begin
			desc_base_q[dst_i]  <= in_base;
			desc_shape_q[dst_i] <= {sat_dim(tile_rows), sat_dim(tile_cols)};
			desc_pitch_q[dst_i] <= {elem_bytes, row_pitch};
		end
	end

	// captured item
	logic [ADDR_BITS-1:0] cap_base_q;
	logic [DIM_W-1:0]     cap_cols_q;
	logic [DIM_W-1:0]     cap_rows_q;
	logic [PITCH_W-1:0]   cap_pitch_q;
	logic [BYTES_W-1:0]   cap_bytes_q;
	logic [IDX_W-1:0]     idx_a_q;
	logic [IDX_W-1:0]     idx_b_q;
	logic [IDX_W-1:0]     idx_c_q;
	logic                 is_mac_q;
	logic                 is_store_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cap_base_q  <= in_base;
			cap_cols_q  <= sat_dim(tile_cols);
			cap_rows_q  <= sat_dim(tile_rows);
			cap_pitch_q <= row_pitch;
			cap_bytes_q <= elem_bytes;
			idx_a_q     <= src_a_tile;
			idx_b_q     <= src_b_tile;
			idx_c_q     <= dest_tile;
			is_mac_q    <= (func == FN_MAC);
			is_store_q  <= (func == FN_STORE);
		end
	end

	// descriptor read for the slot being fetched
	logic [IDX_W-1:0]     rd_sel;
	logic [XIDX_W-1:0]    rd_wide;
	logic                 rd_ok;
	logic [TIDX_W-1:0]    rd_i;
	logic [ADDR_BITS-1:0] f_base;
	logic [DIM_W-1:0]     f_cols;
	logic [DIM_W-1:0]     f_rows;
	logic [PITCH_W-1:0]   f_pitch;
	logic [BYTES_W-1:0]   f_bytes;
	logic [RSTEP_W-1:0]   f_prod;
	logic [ADDR_BITS+RSTEP_W-1:0] f_prod_wide;

	always_comb begin
		case (cmd.slot)
			SLOT_A:  rd_sel = idx_a_q;
			SLOT_B:  rd_sel = idx_b_q;
			default: rd_sel = idx_c_q;
		endcase
	end

	assign rd_wide = {{TIDX_W{1'b0}}, rd_sel};
	assign rd_ok   = rd_wide < XIDX_W'(TILE_REGS);
	assign rd_i    = rd_wide[TIDX_W-1:0];

	always_comb begin
		if (cmd.slot == SLOT_A && !is_mac_q) begin
			f_base  = cap_base_q;
			f_cols  = cap_cols_q;
			f_rows  = cap_rows_q;
			f_pitch = cap_pitch_q;
			f_bytes = cap_bytes_q;
		end else if (rd_ok) begin
			f_base  = desc_base_q[rd_i];
			f_cols  = desc_shape_q[rd_i][DIM_W-1:0];
			f_rows  = desc_shape_q[rd_i][2*DIM_W-1:DIM_W];
			f_pitch = desc_pitch_q[rd_i][PITCH_W-1:0];
			f_bytes = desc_pitch_q[rd_i][RSTEP_W-1:PITCH_W];
		end else begin
			f_base  = '0;
			f_cols  = '0;
			f_rows  = '0;
			f_pitch = '0;
			f_bytes = '0;
		end
	end

	// row step in bytes
	assign f_prod      = {{BYTES_W{1'b0}}, f_pitch} * {{PITCH_W{1'b0}}, f_bytes};
	assign f_prod_wide = {{ADDR_BITS{1'b0}}, f_prod};

	// operand slots
	logic [ADDR_BITS-1:0] slot_base_q  [NSLOT];
	logic [DIM_W-1:0]     slot_cols_q  [NSLOT];
	logic [DIM_W-1:0]     slot_rows_q  [NSLOT];
	logic [BYTES_W-1:0]   slot_bytes_q [NSLOT];
	logic [ADDR_BITS-1:0] slot_rstep_q [NSLOT];

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			slot_base_q[cmd.slot]  <= f_base;
			slot_cols_q[cmd.slot]  <= f_cols;
			slot_rows_q[cmd.slot]  <= f_rows;
			slot_bytes_q[cmd.slot] <= f_bytes;
			slot_rstep_q[cmd.slot] <= f_prod_wide[ADDR_BITS-1:0];
		end
	end

	// loop bounds: rows of A, columns of B (one for load/store), columns of A
	logic [DIM_W-1:0] i_q;
	logic [DIM_W-1:0] j_q;
	logic [DIM_W-1:0] t_q;
	logic [DIM_W-1:0] n_i;
	logic [DIM_W-1:0] n_j;
	logic [DIM_W-1:0] n_t;
	logic             i_end;
	logic             j_end;
	logic             t_end;

	assign n_i   = slot_rows_q[SLOT_A];
	assign n_t   = slot_cols_q[SLOT_A];
	assign n_j   = is_mac_q ? slot_cols_q[SLOT_B] : DIM_W'(1);
	assign i_end = (DIM_W'(i_q + 1'b1) == n_i);
	assign j_end = (DIM_W'(j_q + 1'b1) == n_j);
	assign t_end = (DIM_W'(t_q + 1'b1) == n_t);

	assign stat.load_hit  = in_hit;
	assign stat.is_mac    = is_mac_q;
	assign stat.empty     = (n_i == '0) || (n_j == '0) || (n_t == '0);
	assign stat.last_step = i_end && j_end && t_end;

	// loop counters, inner index fastest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			t_q <= '0;
		end else if (cmd.init) begin
			i_q <= '0;
			j_q <= '0;
			t_q <= '0;
		end else if (cmd.step) begin
			if (!t_end) begin
				t_q <= DIM_W'(t_q + 1'b1);
			end else begin
				t_q <= '0;
				if (!j_end) begin
					j_q <= DIM_W'(j_q + 1'b1);
				end else begin
					j_q <= '0;
					i_q <= DIM_W'(i_q + 1'b1);
				end
			end
		end
	end

	// address pointers, stepped by adds only
	logic [ADDR_BITS-1:0] a_row_q;
	logic [ADDR_BITS-1:0] a_ptr_q;
	logic [ADDR_BITS-1:0] b_col_q;
	logic [ADDR_BITS-1:0] b_ptr_q;
	logic [ADDR_BITS-1:0] c_row_q;
	logic [ADDR_BITS-1:0] c_ptr_q;
	logic [ADDR_BITS-1:0] a_row_nx;
	logic [ADDR_BITS-1:0] b_col_nx;
	logic [ADDR_BITS-1:0] c_row_nx;
	logic                 use_gen_q;

	assign a_row_nx = a_row_q + slot_rstep_q[SLOT_A];
	assign b_col_nx = b_col_q + bytes_ext(slot_bytes_q[SLOT_B]);
	assign c_row_nx = c_row_q + slot_rstep_q[SLOT_C];

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			a_row_q   <= slot_base_q[SLOT_A];
			a_ptr_q   <= slot_base_q[SLOT_A];
			b_col_q   <= slot_base_q[SLOT_B];
			b_ptr_q   <= slot_base_q[SLOT_B];
			c_row_q   <= slot_base_q[SLOT_C];
			c_ptr_q   <= slot_base_q[SLOT_C];
			use_gen_q <= (slot_base_q[SLOT_B] != '0) && (slot_base_q[SLOT_B] == gen_addr_q);
		end else if (cmd.step) begin
			if (!t_end) begin
				a_ptr_q <= a_ptr_q + bytes_ext(slot_bytes_q[SLOT_A]);
				b_ptr_q <= b_ptr_q + slot_rstep_q[SLOT_B];
			end else if (!j_end) begin
				a_ptr_q <= a_row_q;
				b_col_q <= b_col_nx;
				b_ptr_q <= b_col_nx;
				c_ptr_q <= c_ptr_q + bytes_ext(slot_bytes_q[SLOT_C]);
			end else begin
				a_row_q <= a_row_nx;
				a_ptr_q <= a_row_nx;
				b_col_q <= slot_base_q[SLOT_B];
				b_ptr_q <= slot_base_q[SLOT_B];
				c_row_q <= c_row_nx;
				c_ptr_q <= c_row_nx;
			end
		end
	end

	// result register
	logic                    strobe_q;
	kind_t                   kind_q;
	logic [FIELD_ADDR_W-1:0] main_q;
	logic [FIELD_ADDR_W-1:0] b_q;
	logic                    bgen_q;
	logic                    cv_q;
	logic [FIELD_ADDR_W-1:0] c_q;
	logic                    last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.step | cmd.reseed;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reseed) begin
			kind_q <= KIND_RESEED;
			main_q <= to_field(in_base);
			b_q    <= '0;
			bgen_q <= 1'b0;
			cv_q   <= 1'b0;
			c_q    <= '0;
			last_q <= 1'b1;
		end else if (cmd.step) begin
			if (is_mac_q) begin
				kind_q <= KIND_MAC;
			end else if (is_store_q) begin
				kind_q <= KIND_WRITE;
			end else begin
				kind_q <= KIND_READ;
			end
			main_q <= to_field(a_ptr_q);
			b_q    <= (is_mac_q && !use_gen_q) ? to_field(b_ptr_q) : '0;
			bgen_q <= is_mac_q && use_gen_q;
			cv_q   <= is_mac_q && t_end;
			c_q    <= (is_mac_q && t_end) ? to_field(c_ptr_q) : '0;
			last_q <= stat.last_step;
		end
	end

	assign strobe           = strobe_q;
	assign kind             = kind_q;
	assign main_addr        = main_q;
	assign b_addr           = b_q;
	assign b_from_generator = bgen_q;
	assign c_valid          = cv_q;
	assign c_addr           = c_q;
	assign last             = last_q;

endmodule

// File: hdl/tile_access_sequencer.sv
// A reseeding load gives its one result from the idle state. A load/store item passes
// FETCH_A and INIT, a multiply item FETCH_A to FETCH_C and INIT; then the walk gives one
// result per cycle, no gaps, through the result register: rows*cols results for load/store
// (at most 16), at most 64 for multiply. Generator start/stop and reseeds leave busy low.
// Reset: arst_n clears descriptors, generator address, controller and strobe at once.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module tile_access_sequencer #(
	parameter int MAX_TILE_DIM = tas_pkg::MAX_TILE_DIM_DEF,
	parameter int TILE_REGS    = tas_pkg::TILE_REGS_DEF,
	parameter int ADDR_BITS    = tas_pkg::ADDR_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [tas_pkg::FUNC_W-1:0]       func,
	input  logic [tas_pkg::FIELD_ADDR_W-1:0] tile_base,
	input  logic [tas_pkg::DIM_W-1:0]        tile_cols,
	input  logic [tas_pkg::DIM_W-1:0]        tile_rows,
	input  logic [tas_pkg::PITCH_W-1:0]      row_pitch,
	input  logic [tas_pkg::BYTES_W-1:0]      elem_bytes,
	input  logic [tas_pkg::IDX_W-1:0]        dest_tile,
	input  logic [tas_pkg::IDX_W-1:0]        src_a_tile,
	input  logic [tas_pkg::IDX_W-1:0]        src_b_tile,
	output logic                             strobe,
	output logic [tas_pkg::KIND_W-1:0]       kind,
	output logic [tas_pkg::FIELD_ADDR_W-1:0] main_addr,
	output logic [tas_pkg::FIELD_ADDR_W-1:0] b_addr,
	output logic                             b_from_generator,
	output logic                             c_valid,
	output logic [tas_pkg::FIELD_ADDR_W-1:0] c_addr,
	output logic                             last
);
	import tas_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// instruction sequencing
	tas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// descriptors, address walk and result register
	tas_dp #(
		.MAX_TILE_DIM (MAX_TILE_DIM),
		.TILE_REGS    (TILE_REGS),
		.ADDR_BITS    (ADDR_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.func             (func),
		.tile_base        (tile_base),
		.tile_cols        (tile_cols),
		.tile_rows        (tile_rows),
		.row_pitch        (row_pitch),
		.elem_bytes       (elem_bytes),
		.dest_tile        (dest_tile),
		.src_a_tile       (src_a_tile),
		.src_b_tile       (src_b_tile),
		.strobe           (strobe),
		.kind             (kind),
		.main_addr        (main_addr),
		.b_addr           (b_addr),
		.b_from_generator (b_from_generator),
		.c_valid          (c_valid),
		.c_addr           (c_addr),
		.last             (last)
	);

	// a walk emits its results on consecutive cycles
	a_walk_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside an access walk");

	// only multiply steps close an output element
	a_close_is_mac: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && c_valid |-> kind == KIND_MAC)
		else $error("c_valid on a non-multiply result");

	// the final multiply step always closes an output element
	a_mac_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last && kind == KIND_MAC |-> c_valid)
		else $error("multiply ended without closing an element");

	// a reseed is a single result item
	a_reseed_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_RESEED |-> last)
		else $error("reseed not marked last");

endmodule

// File: sim/tas_access_checker.sv
module tas_access_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [tas_pkg::FUNC_W-1:0]       func,
	input  logic [tas_pkg::FIELD_ADDR_W-1:0] tile_base,
	input  logic [tas_pkg::DIM_W-1:0]        tile_cols,
	input  logic [tas_pkg::DIM_W-1:0]        tile_rows,
	input  logic [tas_pkg::PITCH_W-1:0]      row_pitch,
	input  logic [tas_pkg::BYTES_W-1:0]      elem_bytes,
	input  logic [tas_pkg::IDX_W-1:0]        dest_tile,
	input  logic [tas_pkg::IDX_W-1:0]        src_a_tile,
	input  logic [tas_pkg::IDX_W-1:0]        src_b_tile,
	input  logic                             strobe,
	input  logic [tas_pkg::KIND_W-1:0]       kind,
	input  logic [tas_pkg::FIELD_ADDR_W-1:0] main_addr,
	input  logic [tas_pkg::FIELD_ADDR_W-1:0] b_addr,
	input  logic                             b_from_generator,
	input  logic                             c_valid,
	input  logic [tas_pkg::FIELD_ADDR_W-1:0] c_addr,
	input  logic                             last,
	output int unsigned                      pending,
	output int unsigned                      errors
);

	import tas_pkg::*;

	typedef struct packed {
		logic [FIELD_ADDR_W-1:0] base;
		logic [DIM_W-1:0]        cols;
		logic [DIM_W-1:0]        rows;
		logic [PITCH_W-1:0]      pitch;
		logic [BYTES_W-1:0]      bytes;
	} tile_desc_t;

	typedef struct packed {
		kind_t                   kind;
		logic [FIELD_ADDR_W-1:0] main_addr;
		logic [FIELD_ADDR_W-1:0] b_addr;
		logic                    from_gen;
		logic                    c_ok;
		logic [FIELD_ADDR_W-1:0] c_addr;
		logic                    last;
	} access_t;

	tile_desc_t              tile_regs [TILE_REGS_DEF];
	logic [FIELD_ADDR_W-1:0] gen_addr;
	access_t                 expected_accesses [$];

	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
		return (v > MAX_TILE_DIM_DEF) ? DIM_W'(MAX_TILE_DIM_DEF) : v;
	endfunction

	// out-of-range index reads as an all-zero descriptor
	function automatic tile_desc_t fetch_desc(logic [IDX_W-1:0] idx);
		tile_desc_t d;
		d = '0;
		if (idx < TILE_REGS_DEF)
			d = tile_regs[idx];
		return d;
	endfunction

	function automatic logic gen_match(logic [FIELD_ADDR_W-1:0] base);
		return (base != '0) && (base == gen_addr);
	endfunction

	// base + (row*pitch + col)*bytes, wrapping at 48 bits
	function automatic logic [FIELD_ADDR_W-1:0] element_addr(tile_desc_t d,
			int unsigned r, int unsigned c);
		logic [63:0] offset;
		offset = (64'(r) * 64'(d.pitch) + 64'(c)) * 64'(d.bytes);
		return d.base + offset[FIELD_ADDR_W-1:0];
	endfunction

	function automatic void push_access(kind_t k, logic [FIELD_ADDR_W-1:0] m,
			logic [FIELD_ADDR_W-1:0] b, logic g, logic cv, logic [FIELD_ADDR_W-1:0] ca);
		access_t a;
		a.kind      = k;
		a.main_addr = m;
		a.b_addr    = b;
		a.from_gen  = g;
		a.c_ok      = cv;
		a.c_addr    = ca;
		a.last      = 1'b0;
		expected_accesses.push_back(a);
	endfunction

	// work out the accesses caused by the item on the ports
	task automatic predict_item();
		tile_desc_t op;
		tile_desc_t a_desc;
		tile_desc_t b_desc;
		tile_desc_t c_desc;
		kind_t      k;
		logic       b_pops;
		logic       closes;
		int unsigned first;
		first = expected_accesses.size();
		case (func)
			FN_LOAD, FN_STORE: begin
				op.base  = tile_base;
				op.cols  = clamp_dim(tile_cols);
				op.rows  = clamp_dim(tile_rows);
				op.pitch = row_pitch;
				op.bytes = elem_bytes;
				if (dest_tile < TILE_REGS_DEF)
					tile_regs[dest_tile] = op;
				if (func == FN_LOAD && gen_match(op.base)) begin
					push_access(KIND_RESEED, op.base, '0, 1'b0, 1'b0, '0);
				end else begin
					k = (func == FN_LOAD) ? KIND_READ : KIND_WRITE;
					for (int unsigned r = 0; r < op.rows; r++)
						for (int unsigned c = 0; c < op.cols; c++)
							push_access(k, element_addr(op, r, c), '0, 1'b0, 1'b0, '0);
				end
			end
			FN_MAC: begin
				a_desc = fetch_desc(src_a_tile);
				b_desc = fetch_desc(src_b_tile);
				c_desc = fetch_desc(dest_tile);
				b_pops = gen_match(b_desc.base);
				// rows of A, columns of B, inner index last
				for (int unsigned i = 0; i < a_desc.rows; i++)
					for (int unsigned j = 0; j < b_desc.cols; j++)
						for (int unsigned t = 0; t < a_desc.cols; t++) begin
							closes = (t + 1 == a_desc.cols);
							push_access(KIND_MAC, element_addr(a_desc, i, t),
								b_pops ? '0 : element_addr(b_desc, t, j), b_pops, closes,
								closes ? element_addr(c_desc, i, j) : '0);
						end
			end
			FN_GEN_START: gen_addr = tile_base;
			FN_GEN_STOP: gen_addr = '0;
			default: ;
		endcase
		if (expected_accesses.size() > first)
			expected_accesses[$].last = 1'b1;
	endtask

	task automatic check_field(string name, logic [FIELD_ADDR_W-1:0] want,
			logic [FIELD_ADDR_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// compare one access with the oldest expectation
	task automatic check_access();
		access_t want;
		if (expected_accesses.size() == 0) begin
			errors++;
			$display("%0t: unexpected access, expected none, actual kind %h main %h b %h c %h",
				$time, kind, main_addr, b_addr, c_addr);
		end else begin
			want = expected_accesses.pop_front();
			check_field("kind", FIELD_ADDR_W'(want.kind), FIELD_ADDR_W'(kind));
			check_field("main_addr", want.main_addr, main_addr);
			check_field("b_addr", want.b_addr, b_addr);
			check_field("b_from_generator", FIELD_ADDR_W'(want.from_gen),
				FIELD_ADDR_W'(b_from_generator));
			check_field("c_valid", FIELD_ADDR_W'(want.c_ok), FIELD_ADDR_W'(c_valid));
			check_field("c_addr", want.c_addr, c_addr);
			check_field("last", FIELD_ADDR_W'(want.last), FIELD_ADDR_W'(last));
		end
	endtask

	// predict on accepted items, check on strobed accesses
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < TILE_REGS_DEF; n++)
				tile_regs[n] = '0;
			gen_addr = '0;
			expected_accesses.delete();
			pending = 0;
		end else begin
			if (start && !busy)
				predict_item();
			if (strobe)
				check_access();
			pending = expected_accesses.size();
		end
	end

endmodule

// File: sim/tb_top.sv
module tb_top;

	import tas_pkg::*;

	localparam logic [FUNC_W-1:0] FN_RSVD_5 = 3'd5;
	localparam logic [FUNC_W-1:0] FN_RSVD_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;

	localparam int unsigned RANDOM_ITEMS = 190;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [FIELD_ADDR_W-1:0] base;
		logic [DIM_W-1:0]        cols;
		logic [DIM_W-1:0]        rows;
		logic [PITCH_W-1:0]      pitch;
		logic [BYTES_W-1:0]      bytes;
		logic [IDX_W-1:0]        dst;
		logic [IDX_W-1:0]        src_a;
		logic [IDX_W-1:0]        src_b;
	} tile_cmd_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [FUNC_W-1:0]       func;
	logic [FIELD_ADDR_W-1:0] tile_base;
	logic [DIM_W-1:0]        tile_cols;
	logic [DIM_W-1:0]        tile_rows;
	logic [PITCH_W-1:0]      row_pitch;
	logic [BYTES_W-1:0]      elem_bytes;
	logic [IDX_W-1:0]        dest_tile;
	logic [IDX_W-1:0]        src_a_tile;
	logic [IDX_W-1:0]        src_b_tile;
	logic                    strobe;
	logic [KIND_W-1:0]       kind;
	logic [FIELD_ADDR_W-1:0] main_addr;
	logic [FIELD_ADDR_W-1:0] b_addr;
	logic                    b_from_generator;
	logic                    c_valid;
	logic [FIELD_ADDR_W-1:0] c_addr;
	logic                    last;
	int unsigned             pending;
	int unsigned             errors;

	int unsigned             sender_idle_pct;
	int unsigned             quiet_cycles;
	logic [FIELD_ADDR_W-1:0] recent_bases [$];
	logic [FIELD_ADDR_W-1:0] gen_shadow;

	tile_access_sequencer dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.func             (func),
		.tile_base        (tile_base),
		.tile_cols        (tile_cols),
		.tile_rows        (tile_rows),
		.row_pitch        (row_pitch),
		.elem_bytes       (elem_bytes),
		.dest_tile        (dest_tile),
		.src_a_tile       (src_a_tile),
		.src_b_tile       (src_b_tile),
		.strobe           (strobe),
		.kind             (kind),
		.main_addr        (main_addr),
		.b_addr           (b_addr),
		.b_from_generator (b_from_generator),
		.c_valid          (c_valid),
		.c_addr           (c_addr),
		.last             (last)
	);

	tas_access_checker access_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.func             (func),
		.tile_base        (tile_base),
		.tile_cols        (tile_cols),
		.tile_rows        (tile_rows),
		.row_pitch        (row_pitch),
		.elem_bytes       (elem_bytes),
		.dest_tile        (dest_tile),
		.src_a_tile       (src_a_tile),
		.src_b_tile       (src_b_tile),
		.strobe           (strobe),
		.kind             (kind),
		.main_addr        (main_addr),
		.b_addr           (b_addr),
		.b_from_generator (b_from_generator),
		.c_valid          (c_valid),
		.c_addr           (c_addr),
		.last             (last),
		.pending          (pending),
		.errors           (errors)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog on cycles with no item and no access
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((start && !busy) || strobe)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic tile_cmd_t make_cmd(logic [FUNC_W-1:0] f, logic [FIELD_ADDR_W-1:0] b,
			logic [DIM_W-1:0] nc, logic [DIM_W-1:0] nr, logic [PITCH_W-1:0] p,
			logic [BYTES_W-1:0] nb, logic [IDX_W-1:0] d, logic [IDX_W-1:0] sa,
			logic [IDX_W-1:0] sb);
		tile_cmd_t cmd;
		cmd.func  = f;
		cmd.base  = b;
		cmd.cols  = nc;
		cmd.rows  = nr;
		cmd.pitch = p;
		cmd.bytes = nb;
		cmd.dst   = d;
		cmd.src_a = sa;
		cmd.src_b = sb;
		return cmd;
	endfunction

	function automatic logic [FIELD_ADDR_W-1:0] pick_base();
		logic [63:0] wide;
		int unsigned sel;
		sel  = $urandom_range(9);
		wide = {$urandom, $urandom};
		if (sel == 0)
			return '0;
		if (sel == 1)
			return 48'hFFFF_FFFF_FF00 | FIELD_ADDR_W'($urandom_range(255));
		if (sel <= 3 && recent_bases.size() > 0)
			return recent_bases[$urandom_range(recent_bases.size() - 1)];
		return wide[FIELD_ADDR_W-1:0];
	endfunction

	// mostly legal dimensions, sometimes zero or oversized
	function automatic logic [DIM_W-1:0] pick_dim();
		int unsigned v;
		v = $urandom_range(9);
		if (v > 7)
			v = $urandom_range(1, 4);
		return DIM_W'(v);
	endfunction

	function automatic logic [IDX_W-1:0] pick_idx();
		return ($urandom_range(9) == 0) ? IDX_W'(3) : IDX_W'($urandom_range(2));
	endfunction

	function automatic tile_cmd_t random_cmd();
		tile_cmd_t   cmd;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 32)
			cmd.func = FN_LOAD;
		else if (roll < 52)
			cmd.func = FN_STORE;
		else if (roll < 82)
			cmd.func = FN_MAC;
		else if (roll < 90)
			cmd.func = FN_GEN_START;
		else if (roll < 95)
			cmd.func = FN_GEN_STOP;
		else
			cmd.func = FUNC_W'($urandom_range(FN_RSVD_5, FN_RSVD_7));
		cmd.base = pick_base();
		// steer loads and generator starts onto addresses in use
		if (cmd.func == FN_LOAD && gen_shadow != '0 && $urandom_range(3) == 0)
			cmd.base = gen_shadow;
		if (cmd.func == FN_GEN_START && recent_bases.size() > 0 && $urandom_range(1))
			cmd.base = recent_bases[$urandom_range(recent_bases.size() - 1)];
		cmd.cols  = pick_dim();
		cmd.rows  = pick_dim();
		cmd.pitch = $urandom_range(1) ? PITCH_W'($urandom_range(16'hFFFF))
			: PITCH_W'($urandom_range(8));
		cmd.bytes = $urandom_range(1) ? BYTES_W'($urandom_range(255))
			: BYTES_W'(1 << $urandom_range(3));
		cmd.dst   = pick_idx();
		cmd.src_a = pick_idx();
		cmd.src_b = pick_idx();
		return cmd;
	endfunction

	// present one item, with random idle cycles ahead of it
	task automatic issue(input tile_cmd_t cmd);
		logic [63:0] junk;
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			junk       = {$urandom, $urandom};
			start      <= 1'b0;
			func       <= FUNC_W'($urandom_range(7));
			tile_base  <= junk[FIELD_ADDR_W-1:0];
			row_pitch  <= junk[63:48];
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		start      <= 1'b1;
		func       <= cmd.func;
		tile_base  <= cmd.base;
		tile_cols  <= cmd.cols;
		tile_rows  <= cmd.rows;
		row_pitch  <= cmd.pitch;
		elem_bytes <= cmd.bytes;
		dest_tile  <= cmd.dst;
		src_a_tile <= cmd.src_a;
		src_b_tile <= cmd.src_b;
		do @(posedge clk); while (busy);
		// track addresses for later stimulus
		if (cmd.func == FN_LOAD || cmd.func == FN_STORE) begin
			recent_bases.push_back(cmd.base);
			if (recent_bases.size() > 8)
				void'(recent_bases.pop_front());
		end else if (cmd.func == FN_GEN_START) begin
			gen_shadow = cmd.base;
		end else if (cmd.func == FN_GEN_STOP) begin
			gen_shadow = '0;
		end
	endtask

	// stimulus and verdict
	initial begin
		tile_cmd_t   cmd;
		int unsigned real_items;
		arst_n          <= 1'b0;
		start           <= 1'b0;
		func            <= FN_GEN_STOP;
		tile_base       <= '0;
		tile_cols       <= '0;
		tile_rows       <= '0;
		row_pitch       <= '0;
		elem_bytes      <= '0;
		dest_tile       <= '0;
		src_a_tile      <= '0;
		src_b_tile      <= '0;
		gen_shadow      = '0;
		sender_idle_pct = 27;
		real_items      = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes: saturated shape, full pitch and size, wrapping addresses
		issue(make_cmd(FN_LOAD, 48'hFFFF_FFFF_FFF0, 3'd7, 3'd7, 16'hFFFF, 8'hFF, 2'd0, 2'd3,
			2'd3));
		// operands for a small multiply
		issue(make_cmd(FN_LOAD, 48'h0000_0000_1000, 3'd3, 3'd2, 16'd8, 8'd4, 2'd0, 2'd0, 2'd0));
		issue(make_cmd(FN_LOAD, 48'h0000_0000_2000, 3'd2, 3'd3, 16'd2, 8'd2, 2'd1, 2'd0, 2'd0));
		issue(make_cmd(FN_STORE, 48'h0000_0000_3000, 3'd2, 3'd2, 16'd16, 8'd8, 2'd2, 2'd0,
			2'd0));
		issue(make_cmd(FN_MAC, '0, '0, '0, '0, '0, 2'd2, 2'd0, 2'd1));
		// missing descriptors for A, B and C
		issue(make_cmd(FN_MAC, '0, '0, '0, '0, '0, 2'd2, 2'd3, 2'd1));
		issue(make_cmd(FN_MAC, '0, '0, '0, '0, '0, 2'd2, 2'd0, 2'd3));
		issue(make_cmd(FN_MAC, '0, '0, '0, '0, '0, 2'd3, 2'd0, 2'd1));
		// tile index out of range, then an empty store
		issue(make_cmd(FN_LOAD, 48'h0000_0000_0ABC, 3'd1, 3'd5, 16'd3, 8'd1, 2'd3, 2'd0, 2'd0));
		issue(make_cmd(FN_STORE, 48'h0000_0000_0ABC, 3'd2, 3'd0, 16'd3, 8'd1, 2'd3, 2'd0, 2'd0));
		// generator on B's base: pops instead of B reads
		issue(make_cmd(FN_GEN_START, 48'h0000_0000_2000, '0, '0, '0, '0, '0, '0, '0));
		issue(make_cmd(FN_MAC, '0, '0, '0, '0, '0, 2'd2, 2'd0, 2'd1));
		// load on the generator address reseeds and still records the tile
		issue(make_cmd(FN_LOAD, 48'h0000_0000_2000, 3'd4, 3'd4, 16'd4, 8'd2, 2'd1, 2'd0, 2'd0));
		issue(make_cmd(FN_MAC, '0, '0, '0, '0, '0, 2'd2, 2'd0, 2'd1));
		issue(make_cmd(FN_STORE, 48'h0000_0000_2000, 3'd1, 3'd1, 16'd1, 8'd1, 2'd1, 2'd0,
			2'd0));
		issue(make_cmd(FN_GEN_STOP, '0, '0, '0, '0, '0, '0, '0, '0));
		issue(make_cmd(FN_LOAD, 48'h0000_0000_2000, 3'd2, 3'd1, 16'd1, 8'd4, 2'd1, 2'd0, 2'd0));
		// zero base never matches, even with the generator started at zero
		issue(make_cmd(FN_GEN_START, '0, '0, '0, '0, '0, '0, '0, '0));
		issue(make_cmd(FN_LOAD, '0, 3'd2, 3'd1, 16'd5, 8'd1, 2'd0, 2'd0, 2'd0));
		issue(make_cmd(FN_MAC, '0, '0, '0, '0, '0, 2'd2, 2'd1, 2'd0));
		// zero inner dimension
		issue(make_cmd(FN_LOAD, 48'h0000_0000_4000, 3'd0, 3'd4, 16'd1, 8'd1, 2'd0, 2'd0, 2'd0));
		issue(make_cmd(FN_MAC, '0, '0, '0, '0, '0, 2'd2, 2'd0, 2'd1));
		// unused codes
		issue(make_cmd(FN_RSVD_5, 48'hFFFF_FFFF_FFFF, 3'd7, 3'd7, 16'hFFFF, 8'hFF, 2'd3, 2'd3,
			2'd3));
		issue(make_cmd(FN_RSVD_6, '0, '0, '0, '0, '0, '0, '0, '0));
		issue(make_cmd(FN_RSVD_7, '0, '0, '0, '0, '0, '0, '0, '0));
		// full size multiply with wrapping operands
		issue(make_cmd(FN_LOAD, 48'hFFFF_FFFF_0000, 3'd4, 3'd4, 16'hFFFF, 8'hFF, 2'd0, 2'd0,
			2'd0));
		issue(make_cmd(FN_MAC, '0, '0, '0, '0, '0, 2'd0, 2'd0, 2'd0));

		// random items in three idle phases
		while (real_items < RANDOM_ITEMS) begin
			if (real_items < RANDOM_ITEMS / 3)
				sender_idle_pct = 27;
			else if (real_items < 2 * RANDOM_ITEMS / 3)
				sender_idle_pct = 77;
			else
				sender_idle_pct = 0;
			cmd = random_cmd();
			issue(cmd);
			if (cmd.func <= FN_GEN_STOP)
				real_items++;
		end
		start <= 1'b0;

		// drain outstanding accesses, then watch for strays
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
